/* rtl/core/tags_pkg.sv */
`default_nettype none
package tags_pkg;

	// field widths
	localparam int CoordW  = 16;   // Q12.4 vertex coordinate
	localparam int DeltaW  = 17;   // edge delta
	localparam int AttrW   = 32;   // Q16.16 attribute
	localparam int DiffW   = 33;   // attribute difference
	localparam int DetW    = 35;   // determinant, Q.8
	localparam int ProdW   = DiffW + DeltaW;    // one product of the shared multiplier
	localparam int AccW    = ProdW + 1;         // difference of two products
	localparam int ScaledW = AccW + 4;          // numerator times 16
	localparam int StepW   = 32;   // Q16.16 step
	localparam int IterW   = $clog2(StepW);     // quotient bit counter

	localparam logic [StepW-1:0] StepMax = {1'b0, {(StepW-1){1'b1}}};
	localparam logic [StepW-1:0] StepMin = {1'b1, {(StepW-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GEO_MUL0,
		ST_GEO_MUL1,
		ST_GEO_ACC0,
		ST_GEO_ACC1,
		ST_ATT_MUL0,
		ST_ATT_MUL1,
		ST_ATT_MUL2,
		ST_ATT_MUL3,
		ST_DIV_X,
		ST_DIV_Y,
		ST_RESULT
	} tags_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_CHECK,
		DV_RUN,
		DV_FIN
	} tags_div_state_t;

	// control of the shared multiply-accumulate unit
	typedef struct packed {
		logic vld;   // issue a product
		logic clr;   // product starts a new sum
		logic sub;   // product is subtracted
	} tags_mac_req_t;

	// divider status towards the sequencer
	typedef struct packed {
		logic             done;
		logic             sat;
		logic [StepW-1:0] quot;
	} tags_div_res_t;

endpackage
`default_nettype wire

/* rtl/core/tags_mac.sv */
`default_nettype none
module tags_mac (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire tags_pkg::tags_mac_req_t          req,
	input  wire signed [tags_pkg::DiffW-1:0]      a,
	input  wire signed [tags_pkg::DeltaW-1:0]     b,
	output logic signed [tags_pkg::AccW-1:0]      acc
);
	import tags_pkg::*;

	logic signed [ProdW-1:0] prod_s1;
	tags_mac_req_t           ctl_s1;
	logic signed [AccW-1:0]  acc_q;
	logic signed [AccW-1:0]  base;
	logic signed [AccW-1:0]  term;

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= req;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	// accumulate stage
	always_comb begin
		base = ctl_s1.clr ? '0 : acc_q;
		term = {{(AccW-ProdW){prod_s1[ProdW-1]}}, prod_s1};
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.vld) begin
			acc_q <= ctl_s1.sub ? base - term : base + term;
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

/* rtl/core/tags_div.sv */
`default_nettype none
module tags_div (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	input  wire signed [tags_pkg::AccW-1:0]      num,
	input  wire signed [tags_pkg::DetW-1:0]      den,
	output tags_pkg::tags_div_res_t              res
);
	import tags_pkg::*;

	localparam int HiW = ScaledW - StepW;   // numerator bits above the quotient window

	tags_div_state_t      state_q, state_d;
	logic [ScaledW-1:0]   num_mag_q;
	logic [DetW-1:0]      den_mag_q;
	logic                 neg_q;
	logic                 big_q;
	logic [DetW-1:0]      rem_q;
	logic [StepW-1:0]     lo_q;
	logic [IterW-1:0]     cnt_q;
	logic signed [ScaledW-1:0] num_s;
	logic [DetW:0]        trial;
	logic                 fits;

	assign num_s = {num, 4'b0000};
	assign trial = {rem_q, lo_q[StepW-1]};
	assign fits  = trial >= {1'b0, den_mag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		res     = '0;
		case (state_q)
			DV_IDLE: state_d = DV_IDLE;
			DV_CHECK: state_d = DV_RUN;
			DV_RUN: begin
				if (cnt_q == {IterW{1'b1}}) begin
					state_d = DV_FIN;
				end
			end
			DV_FIN: begin
				state_d  = DV_IDLE;
				res.done = 1'b1;
				// quotient magnitude of 2^32 or more is caught before the run
				if (big_q) begin
					res.sat  = 1'b1;
					res.quot = neg_q ? StepMin : StepMax;
				end else if (!neg_q && lo_q[StepW-1]) begin
					res.sat  = 1'b1;
					res.quot = StepMax;
				end else if (neg_q && lo_q > StepMin) begin
					res.sat  = 1'b1;
					res.quot = StepMin;
				end else begin
					res.quot = neg_q ? StepW'(-lo_q) : lo_q;
				end
			end
			default: state_d = DV_IDLE;
		endcase
		if (start) begin
			state_d = DV_CHECK;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_mag_q <= num_s[ScaledW-1] ? ScaledW'(-num_s) : num_s;
			den_mag_q <= den[DetW-1] ? DetW'(-den) : den;
			neg_q     <= num_s[ScaledW-1] ^ den[DetW-1];
		end else if (state_q == DV_CHECK) begin
			big_q <= {{(DetW-HiW){1'b0}}, num_mag_q[ScaledW-1:StepW]} >= den_mag_q;
			rem_q <= {{(DetW-HiW){1'b0}}, num_mag_q[ScaledW-1:StepW]};
			lo_q  <= num_mag_q[StepW-1:0];
			cnt_q <= '0;
		end else if (state_q == DV_RUN) begin
			// restoring step: one quotient bit a cycle
			rem_q <= fits ? DetW'(trial - {1'b0, den_mag_q}) : trial[DetW-1:0];
			lo_q  <= {lo_q[StepW-2:0], fits};
			cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/triangle_attribute_gradient_setup.sv */
`default_nettype none
// Triangle setup for plane-equation attribute interpolation. A geometry request
// (tuser = 0) carries three Q12.4 vertices; the block keeps the edge deltas
// against vertex 2 and the determinant dx1*dy0 - dx0*dy1, and answers with zero
// steps and a degenerate flag that is set when the determinant is zero. Each
// attribute request (tuser = 1) carries one Q16.16 attribute at the three
// vertices and is answered with its per-pixel x and y steps in Q16.16, each the
// numerator times 16 over the determinant, truncated toward zero and saturated,
// with clipped set when either step saturated. Requests are taken one at a time;
// a geometry request passes two products through the shared multiply-accumulate
// unit, then two accumulate steps; an attribute request four products through
// that unit, then two runs of the radix-2 divider, each a range check, 32
// quotient bits one a cycle and a finishing step; an attribute request against
// a zero determinant none of these. All end in a result step that loads the
// output register. The result shows on the output in the cycle the block is
// ready again; a result held by back-pressure keeps the block in its last step
// until the output register is free. Before the first geometry request the
// determinant reads as zero.
module triangle_attribute_gradient_setup (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// x0, y0, x1, y1, x2, y2 (16 bits each), attr0, attr1, attr2 (32 bits each)
	input  wire  [191:0] s_axis_tdata,
	// func
	input  wire          s_axis_tuser,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// x_step, y_step (32 bits each)
	output logic [63:0]  m_axis_tdata,
	// degenerate, clipped
	output logic [1:0]   m_axis_tuser
);
	import tags_pkg::*;

	// request fields
	logic signed [CoordW-1:0] in_x0, in_y0, in_x1, in_y1, in_x2, in_y2;
	logic signed [AttrW-1:0]  in_a0, in_a1, in_a2;
	logic                     in_func;
	logic                     in_acc;

	assign in_x0   = s_axis_tdata[15:0];
	assign in_y0   = s_axis_tdata[31:16];
	assign in_x1   = s_axis_tdata[47:32];
	assign in_y1   = s_axis_tdata[63:48];
	assign in_x2   = s_axis_tdata[79:64];
	assign in_y2   = s_axis_tdata[95:80];
	assign in_a0   = s_axis_tdata[127:96];
	assign in_a1   = s_axis_tdata[159:128];
	assign in_a2   = s_axis_tdata[191:160];
	assign in_func = s_axis_tuser;

	tags_state_t state_q, state_d;

	// triangle state, kept between requests
	logic signed [DeltaW-1:0] dx0_q, dx1_q, dy0_q, dy1_q;
	logic signed [DetW-1:0]   det_q;

	// attribute differences against vertex 2
	logic signed [DiffW-1:0]  d0_q, d1_q;

	// steps collected for the result
	logic [StepW-1:0]         xs_q, ys_q;
	logic                     sat_q;

	// output register
	logic                     out_vld_q;
	logic [2*StepW-1:0]       out_data_q;
	logic [1:0]               out_user_q;
	logic                     out_free;

	// shared multiply-accumulate unit
	tags_mac_req_t            mac_req;
	logic signed [DiffW-1:0]  mac_a;
	logic signed [DeltaW-1:0] mac_b;
	logic signed [AccW-1:0]   mac_acc;

	// shared divider
	logic                     div_start;
	tags_div_res_t            div_res;

	logic                     det_zero;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign out_free      = !out_vld_q || m_axis_tready;
	assign det_zero      = (det_q == '0);

	tags_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.a      (mac_a),
		.b      (mac_b),
		.acc    (mac_acc)
	);

	tags_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mac_acc),
		.den    (det_q),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: which products go through the shared unit and when
	always_comb begin
		state_d   = state_q;
		mac_req   = '0;
		mac_a     = d0_q;
		mac_b     = dy1_q;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (!in_func) begin
						state_d = ST_GEO_MUL0;
					end else if (det_zero) begin
						state_d = ST_RESULT;
					end else begin
						state_d = ST_ATT_MUL0;
					end
				end
			end
			// det = dx1*dy0 - dx0*dy1
			ST_GEO_MUL0: begin
				mac_req = '{vld: 1'b1, clr: 1'b1, sub: 1'b0};
				mac_a   = {{(DiffW-DeltaW){dx1_q[DeltaW-1]}}, dx1_q};
				mac_b   = dy0_q;
				state_d = ST_GEO_MUL1;
			end
			ST_GEO_MUL1: begin
				mac_req = '{vld: 1'b1, clr: 1'b0, sub: 1'b1};
				mac_a   = {{(DiffW-DeltaW){dx0_q[DeltaW-1]}}, dx0_q};
				mac_b   = dy1_q;
				state_d = ST_GEO_ACC0;
			end
			ST_GEO_ACC0: state_d = ST_GEO_ACC1;
			ST_GEO_ACC1: state_d = ST_RESULT;
			// x numerator = d1*dy0 - d0*dy1
			ST_ATT_MUL0: begin
				mac_req = '{vld: 1'b1, clr: 1'b1, sub: 1'b0};
				mac_a   = d1_q;
				mac_b   = dy0_q;
				state_d = ST_ATT_MUL1;
			end
			ST_ATT_MUL1: begin
				mac_req = '{vld: 1'b1, clr: 1'b0, sub: 1'b1};
				mac_a   = d0_q;
				mac_b   = dy1_q;
				state_d = ST_ATT_MUL2;
			end
			// y numerator = d0*dx1 - d1*dx0, overlapping the x division
			ST_ATT_MUL2: begin
				mac_req = '{vld: 1'b1, clr: 1'b1, sub: 1'b0};
				mac_a   = d0_q;
				mac_b   = dx1_q;
				state_d = ST_ATT_MUL3;
			end
			ST_ATT_MUL3: begin
				// accumulator holds the x numerator here
				mac_req   = '{vld: 1'b1, clr: 1'b0, sub: 1'b1};
				mac_a     = d1_q;
				mac_b     = dx0_q;
				div_start = 1'b1;
				state_d   = ST_DIV_X;
			end
			ST_DIV_X: begin
				// y numerator has long settled by the time x is done
				if (div_res.done) begin
					div_start = 1'b1;
					state_d   = ST_DIV_Y;
				end
			end
			ST_DIV_Y: begin
				if (div_res.done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// triangle state resets to an empty triangle (zero determinant)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx0_q <= '0;
			dx1_q <= '0;
			dy0_q <= '0;
			dy1_q <= '0;
			det_q <= '0;
		end else begin
			if (in_acc && !in_func) begin
				dx0_q <= {in_x0[CoordW-1], in_x0} - {in_x2[CoordW-1], in_x2};
				dx1_q <= {in_x1[CoordW-1], in_x1} - {in_x2[CoordW-1], in_x2};
				dy0_q <= {in_y0[CoordW-1], in_y0} - {in_y2[CoordW-1], in_y2};
				dy1_q <= {in_y1[CoordW-1], in_y1} - {in_y2[CoordW-1], in_y2};
			end
			if (state_q == ST_GEO_ACC1) begin
				det_q <= mac_acc[DetW-1:0];
			end
		end
	end

	// per-request working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			d0_q  <= {in_a0[AttrW-1], in_a0} - {in_a2[AttrW-1], in_a2};
			d1_q  <= {in_a1[AttrW-1], in_a1} - {in_a2[AttrW-1], in_a2};
			xs_q  <= '0;
			ys_q  <= '0;
			sat_q <= 1'b0;
		end else if (state_q == ST_DIV_X && div_res.done) begin
			xs_q  <= div_res.quot;
			sat_q <= div_res.sat;
		end else if (state_q == ST_DIV_Y && div_res.done) begin
			ys_q  <= div_res.quot;
			sat_q <= sat_q | div_res.sat;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_RESULT && out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && out_free) begin
			out_data_q <= {ys_q, xs_q};
			out_user_q <= {sat_q, det_zero};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule
`default_nettype wire

/* rtl/core/tags_chk.sv */
`default_nettype none
module tags_chk (
	input wire         clk,
	input wire         arst_n,
	input wire         s_axis_tvalid,
	input wire         s_axis_tready,
	input wire         m_axis_tvalid,
	input wire         m_axis_tready,
	input wire [63:0]  m_axis_tdata,
	input wire [1:0]   m_axis_tuser
);
	import tags_pkg::*;

	logic [StepW-1:0] x_step;
	logic [StepW-1:0] y_step;

	assign x_step = m_axis_tdata[StepW-1:0];
	assign y_step = m_axis_tdata[2*StepW-1:StepW];

	// one request at a time: busy right after a request is taken
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while the previous one is in progress");

	// a held result must not change
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result changed");

	// degenerate triangle gives zero steps and no saturation
	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
		else $error("degenerate result with non-zero steps");

	// saturation leaves at least one step at a range limit
	a_clipped_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |->
			x_step == StepMax || x_step == StepMin || y_step == StepMax || y_step == StepMin)
		else $error("clipped result with no step at a limit");

endmodule

bind triangle_attribute_gradient_setup tags_chk u_tags_chk (.*);
`default_nettype wire

/* tb/triangle_attribute_gradient_setup_tb.sv */
`default_nettype none
module triangle_attribute_gradient_setup_tb;

	localparam bit FUNC_GEOMETRY  = 1'b0;
	localparam bit FUNC_ATTRIBUTE = 1'b1;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_CYCLES = 100;

	localparam longint STEP_HI = 64'sd2147483647;
	localparam longint STEP_LO = -64'sd2147483648;

	typedef struct {
		bit      func;
		shortint x0, y0, x1, y1, x2, y2;
		int      attr0, attr1, attr2;
	} setup_req_t;

	typedef struct {
		int x_step;
		int y_step;
		bit degenerate;
		bit clipped;
	} gradient_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [191:0] s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	triangle_attribute_gradient_setup dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	setup_req_t pending_reqs[$];
	gradient_t  expected_steps[$];
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         accepted_reqs = 0;
	int         failures = 0;
	int         cycle_count = 0;
	logic       hold_active = 1'b0;

	// triangle state as the block should hold it
	int     tri_dx0 = 0, tri_dx1 = 0, tri_dy0 = 0, tri_dy1 = 0;
	longint tri_det = 0;

	function automatic int clamp_step(longint q, inout bit sat);
		if (q > STEP_HI) begin
			sat = 1'b1;
			return int'(STEP_HI);
		end
		if (q < STEP_LO) begin
			sat = 1'b1;
			return int'(STEP_LO);
		end
		return int'(q);
	endfunction

	// updates the triangle state and works out the result of one request
	function automatic gradient_t predict_gradients(setup_req_t r);
		gradient_t g;
		longint    d0, d1, nx, ny;
		bit        sat;
		g.x_step = 0;
		g.y_step = 0;
		sat = 1'b0;
		if (r.func == FUNC_GEOMETRY) begin
			tri_dx0 = r.x0 - r.x2;
			tri_dx1 = r.x1 - r.x2;
			tri_dy0 = r.y0 - r.y2;
			tri_dy1 = r.y1 - r.y2;
			tri_det = longint'(tri_dx1) * tri_dy0 - longint'(tri_dx0) * tri_dy1;
		end else if (tri_det != 0) begin
			d0 = longint'(r.attr0) - r.attr2;
			d1 = longint'(r.attr1) - r.attr2;
			nx = d1 * tri_dy0 - d0 * tri_dy1;
			ny = d0 * tri_dx1 - d1 * tri_dx0;
			// division truncates toward zero
			g.x_step = clamp_step((nx * 16) / tri_det, sat);
			g.y_step = clamp_step((ny * 16) / tri_det, sat);
		end
		g.degenerate = (tri_det == 0);
		g.clipped = sat;
		return g;
	endfunction

	function automatic setup_req_t make_req(bit func, shortint x0, shortint y0,
			shortint x1, shortint y1, shortint x2, shortint y2,
			int a0, int a1, int a2);
		setup_req_t r;
		r.func = func;
		r.x0 = x0; r.y0 = y0;
		r.x1 = x1; r.y1 = y1;
		r.x2 = x2; r.y2 = y2;
		r.attr0 = a0; r.attr1 = a1; r.attr2 = a2;
		return r;
	endfunction

	function automatic shortint rand_coord(int mode);
		shortint corners[5] = '{-32768, -32767, 0, 32766, 32767};
		case (mode)
			0: return shortint'($urandom);
			1: return shortint'(int'($urandom_range(0, 4095)) - 2048);
			default: return corners[$urandom_range(0, 4)];
		endcase
	endfunction

	function automatic int rand_attr(int mode);
		int corners[5] = '{32'h8000_0000, 32'h8000_0001, 0, 32'h7fff_fffe, 32'h7fff_ffff};
		case (mode)
			0: return int'($urandom);
			1: return int'($urandom_range(0, 2097151)) - 1048576;
			default: return corners[$urandom_range(0, 4)];
		endcase
	endfunction

	function automatic setup_req_t rand_geometry();
		setup_req_t r;
		int         mode;
		mode = $urandom_range(0, 2);
		r = make_req(FUNC_GEOMETRY, rand_coord(mode), rand_coord(mode), rand_coord(mode),
			rand_coord(mode), rand_coord(mode), rand_coord(mode),
			int'($urandom), int'($urandom), int'($urandom));
		// now and then a collapsed triangle
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 2))
				0: begin r.x2 = r.x0; r.y2 = r.y0; end
				1: begin r.x1 = r.x0; r.y1 = r.y0; end
				default: begin r.x1 = r.x2; r.y1 = r.y2; end
			endcase
		end
		return r;
	endfunction

	function automatic setup_req_t rand_attribute();
		int mode;
		mode = $urandom_range(0, 2);
		return make_req(FUNC_ATTRIBUTE, shortint'($urandom), shortint'($urandom),
			shortint'($urandom), shortint'($urandom), shortint'($urandom),
			shortint'($urandom), rand_attr(mode), rand_attr(mode), rand_attr(mode));
	endfunction

	task automatic queue_directed();
		// attribute before any triangle sees the zero determinant
		pending_reqs.push_back(make_req(FUNC_ATTRIBUTE, 100, -200, 300, -400, 500, -600,
			1, 2, 3));
		pending_reqs.push_back(make_req(FUNC_GEOMETRY, 0, 0, 16, 0, 0, 16,
			32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678));
		pending_reqs.push_back(make_req(FUNC_ATTRIBUTE, 0, 0, 0, 0, 0, 0, 65536, 0, 0));
		pending_reqs.push_back(make_req(FUNC_ATTRIBUTE, -1, -1, -1, -1, -1, -1,
			32'h7fff_ffff, 32'h8000_0000, 0));
		pending_reqs.push_back(make_req(FUNC_ATTRIBUTE, 0, 0, 0, 0, 0, 0,
			32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
		pending_reqs.push_back(make_req(FUNC_ATTRIBUTE, 0, 0, 0, 0, 0, 0, 5, 5, 5));
		// collinear vertices
		pending_reqs.push_back(make_req(FUNC_GEOMETRY, 0, 0, 16, 16, 32, 32, 0, 0, 0));
		pending_reqs.push_back(make_req(FUNC_ATTRIBUTE, 0, 0, 0, 0, 0, 0,
			32'h7fff_ffff, -7, 32'h8000_0000));
		// largest triangles, both of the same winding
		pending_reqs.push_back(make_req(FUNC_GEOMETRY, -32768, -32768, 32767, -32768,
			-32768, 32767, 0, 0, 0));
		pending_reqs.push_back(make_req(FUNC_ATTRIBUTE, 0, 0, 0, 0, 0, 0,
			32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
		pending_reqs.push_back(make_req(FUNC_ATTRIBUTE, 0, 0, 0, 0, 0, 0,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
		pending_reqs.push_back(make_req(FUNC_GEOMETRY, 32767, 32767, -32768, 32767,
			32767, -32768, -1, -1, -1));
		pending_reqs.push_back(make_req(FUNC_ATTRIBUTE, 0, 0, 0, 0, 0, 0,
			32'h7fff_ffff, 0, 32'h8000_0000));
		// unit determinant: steps overflow easily
		pending_reqs.push_back(make_req(FUNC_GEOMETRY, 0, 0, 1, 0, 0, 1, 0, 0, 0));
		pending_reqs.push_back(make_req(FUNC_ATTRIBUTE, 0, 0, 0, 0, 0, 0, 65536, 0, 0));
		pending_reqs.push_back(make_req(FUNC_ATTRIBUTE, 0, 0, 0, 0, 0, 0,
			32'h7fff_ffff, 32'h8000_0000, 0));
		pending_reqs.push_back(make_req(FUNC_ATTRIBUTE, 0, 0, 0, 0, 0, 0,
			32'h8000_0000, 32'h7fff_ffff, 0));
		pending_reqs.push_back(make_req(FUNC_ATTRIBUTE, 0, 0, 0, 0, 0, 0, -1, 1, 0));
		pending_reqs.push_back(make_req(FUNC_GEOMETRY, 160, 32, -48, 400, 1000, -16,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
		pending_reqs.push_back(rand_attribute());
	endtask

	// mostly a triangle followed by a few attributes, the rest loose requests
	task automatic queue_random(int count);
		int queued;
		int n_attr;
		queued = 0;
		while (queued < count) begin
			if ($urandom_range(0, 9) < 8) begin
				pending_reqs.push_back(rand_geometry());
				n_attr = $urandom_range(1, 6);
				repeat (n_attr) pending_reqs.push_back(rand_attribute());
				queued += 1 + n_attr;
			end else begin
				pending_reqs.push_back($urandom_range(0, 1) ? rand_attribute()
					: rand_geometry());
				queued++;
			end
		end
	endtask

	// request side
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_steps.push_back(predict_gradients(pending_reqs.pop_front()));
				accepted_reqs <= accepted_reqs + 1;
			end
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tuser  <= pending_reqs[0].func;
					s_axis_tdata  <= {pending_reqs[0].attr2, pending_reqs[0].attr1,
						pending_reqs[0].attr0, pending_reqs[0].y2, pending_reqs[0].x2,
						pending_reqs[0].y1, pending_reqs[0].x1, pending_reqs[0].y0,
						pending_reqs[0].x0};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result side
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin : check_result
				gradient_t want;
				if (expected_steps.size() == 0) begin
					$error("unexpected result x_step %0d y_step %0d",
						$signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]));
					failures++;
				end else begin
					want = expected_steps.pop_front();
					if (m_axis_tdata[31:0] !== want.x_step) begin
						$error("x_step: expected %0d, got %0d", want.x_step,
							$signed(m_axis_tdata[31:0]));
						failures++;
					end
					if (m_axis_tdata[63:32] !== want.y_step) begin
						$error("y_step: expected %0d, got %0d", want.y_step,
							$signed(m_axis_tdata[63:32]));
						failures++;
					end
					if (m_axis_tuser[0] !== want.degenerate) begin
						$error("degenerate: expected %0d, got %0d", want.degenerate,
							m_axis_tuser[0]);
						failures++;
					end
					if (m_axis_tuser[1] !== want.clipped) begin
						$error("clipped: expected %0d, got %0d", want.clipped,
							m_axis_tuser[1]);
						failures++;
					end
				end
			end
			m_axis_tready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// one long back-pressure stretch early on so the block fills up
	initial begin
		while (accepted_reqs < 30) @(negedge clk);
		@(posedge clk);
		hold_active <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int send_pct[4];
		int recv_pct[4];
		send_pct = '{0, 82, 0, 24};
		recv_pct = '{0, 0, 82, 24};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < 4; phase++) begin
			@(negedge clk);
			send_idle_pct = send_pct[phase];
			recv_stall_pct = recv_pct[phase];
			if (phase == 0)
				queue_directed();
			queue_random(275);
			while (pending_reqs.size() != 0 || expected_steps.size() != 0)
				@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
